// ----- src/bsl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded shift list package
// Shared widths, action and status codes, cell commands and beat types.
// ----------------------------------------------------------------------------
package bsl_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int WORD_W = 32;

  localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd10;

  // Request actions.
  localparam logic [3:0] ACT_APPEND     = 4'd0;
  localparam logic [3:0] ACT_PREPEND    = 4'd1;
  localparam logic [3:0] ACT_INSERT_AT  = 4'd2;
  localparam logic [3:0] ACT_SORTED_INS = 4'd3;
  localparam logic [3:0] ACT_REMOVE_AT  = 4'd4;
  localparam logic [3:0] ACT_REMOVE_LST = 4'd5;
  localparam logic [3:0] ACT_REMOVE_FST = 4'd6;
  localparam logic [3:0] ACT_REMOVE_VAL = 4'd7;
  localparam logic [3:0] ACT_FIND       = 4'd8;
  localparam logic [3:0] ACT_READ_AT    = 4'd9;
  localparam logic [3:0] ACT_WRITE_AT   = 4'd10;

  // Result status.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // Operations broadcast to the cell chain.
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_INS   = 2'd1;
  localparam logic [1:0] CELL_DEL   = 2'd2;
  localparam logic [1:0] CELL_WRITE = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] word;
  } cell_cmd_t;

  typedef struct packed {
    logic [3:0]        action;
    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  position;
    logic              wipe;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_out;
    logic [CNT_W-1:0]  found_at;
    logic [CNT_W-1:0]  entry_count;
    logic              is_full;
    logic              is_empty;
    logic [1:0]        status;
  } out_t;

endpackage

// ----- src/bsl_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded shift list cell
// Holds one list entry, shifts to or from its neighbours and compares its word.
// ----------------------------------------------------------------------------
module bsl_cell (
  input  logic                       clk,
  input  logic [bsl_pkg::IDX_W-1:0]  cell_idx,
  input  bsl_pkg::cell_cmd_t         cmd,
  input  logic [bsl_pkg::WORD_W-1:0] left_word,
  input  logic [bsl_pkg::WORD_W-1:0] right_word,
  output logic [bsl_pkg::WORD_W-1:0] word,
  output logic                       le,
  output logic                       eq
);

  logic [bsl_pkg::WORD_W-1:0] word_r;
  logic [bsl_pkg::WORD_W-1:0] word_nxt;
  logic [bsl_pkg::CNT_W-1:0]  pos;
  logic                       in_use;

  assign pos    = {1'b0, cell_idx};
  assign in_use = pos < cmd.count;

  always_comb begin
    word_nxt = word_r;
    unique case (cmd.op)
      bsl_pkg::CELL_INS: begin
        if (cell_idx == cmd.idx) begin
          word_nxt = cmd.word;
        end else if (cell_idx > cmd.idx && pos <= cmd.count) begin
          word_nxt = left_word;
        end
      end
      bsl_pkg::CELL_DEL: begin
        if (cell_idx >= cmd.idx && (pos + 5'd1) < cmd.count) begin
          word_nxt = right_word;
        end
      end
      bsl_pkg::CELL_WRITE: begin
        if (cell_idx == cmd.idx) begin
          word_nxt = cmd.word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  assign le   = in_use && (word_r <= cmd.word);
  assign eq   = in_use && (word_r == cmd.word);

endmodule

// ----- src/bounded_shift_list_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded shift list engine
// Fixed-capacity ordered list of words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Result strobe: registered, in the cycle after an accepted request for every
// action except remove value, whose strobe follows the purge finding no match.
// Throughput: one request per cycle; remove value holds busy while the chain
// deletes one matching entry per cycle. The receiver cannot stall results.
// Reset (rst_n low, synchronous): list empty, capacity limit 10, no result.
// ----------------------------------------------------------------------------
module bounded_shift_list_engine_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bsl_pkg::in_t                  in_data,
  output logic                          out_strobe,
  output bsl_pkg::out_t                 out_data,
  input  logic                          cfg_wr_en,
  input  logic [bsl_pkg::CNT_W-1:0]     cfg_wr_data
);

  // The controller runs a two-state machine: idle, where every request but
  // remove value is resolved directly, and purge, where a remove-value request
  // deletes the first matching entry each cycle until no match remains.
  localparam logic STATE_IDLE  = 1'b0;
  localparam logic STATE_PURGE = 1'b1;

  logic                          state_r;
  logic                          state_nxt;
  logic [bsl_pkg::CNT_W-1:0]     count_r;
  logic [bsl_pkg::CNT_W-1:0]     count_nxt;
  logic [bsl_pkg::CNT_W-1:0]     cap_r;
  logic [bsl_pkg::WORD_W-1:0]    key_r;
  logic [bsl_pkg::WORD_W-1:0]    key_nxt;
  logic                          out_strobe_r;
  logic                          out_strobe_nxt;
  bsl_pkg::out_t                 out_data_r;
  bsl_pkg::out_t                 out_data_nxt;

  bsl_pkg::cell_cmd_t            cmd;
  logic [bsl_pkg::WORD_W-1:0]    cell_word [bsl_pkg::DEPTH];
  logic [bsl_pkg::DEPTH-1:0]     le_flags;
  logic [bsl_pkg::DEPTH-1:0]     eq_flags;

  logic                          accept;
  logic [bsl_pkg::CNT_W-1:0]     eff_limit;
  logic                          full_now;
  logic [bsl_pkg::CNT_W-1:0]     first_eq;
  logic                          any_eq;
  logic [bsl_pkg::CNT_W-1:0]     sorted_pos;
  logic [bsl_pkg::IDX_W-1:0]     rd_idx;
  logic [bsl_pkg::WORD_W-1:0]    rd_word;

  assign accept    = start && !busy;
  assign busy      = (state_r != STATE_IDLE);
  assign eff_limit = (cap_r > 5'(bsl_pkg::DEPTH)) ? 5'(bsl_pkg::DEPTH) : cap_r;
  assign full_now  = count_r >= eff_limit;

  // Chain of cells: each takes its left neighbour on insertion and its right
  // neighbour on deletion. The ends of the chain see zero words.
  genvar g;
  generate
    for (g = 0; g < bsl_pkg::DEPTH; g++) begin : g_cell
      logic [bsl_pkg::WORD_W-1:0] left_w;
      logic [bsl_pkg::WORD_W-1:0] right_w;

      if (g == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_word[g-1];
      end

      if (g == bsl_pkg::DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_word[g+1];
      end

      bsl_cell u_cell (
        .clk        (clk),
        .cell_idx   (bsl_pkg::IDX_W'(g)),
        .cmd        (cmd),
        .left_word  (left_w),
        .right_word (right_w),
        .word       (cell_word[g]),
        .le         (le_flags[g]),
        .eq         (eq_flags[g])
      );
    end
  endgenerate

  // First in-use entry equal to the key, or the count when there is none.
  always_comb begin
    first_eq = count_r;
    any_eq   = |eq_flags;
    for (int i = bsl_pkg::DEPTH - 1; i >= 0; i--) begin
      if (eq_flags[i]) begin
        first_eq = bsl_pkg::CNT_W'(i);
      end
    end
  end

  // Sorted insertion point: just after the last in-use entry not above the key.
  always_comb begin
    sorted_pos = '0;
    for (int i = 0; i < bsl_pkg::DEPTH; i++) begin
      if (le_flags[i]) begin
        sorted_pos = bsl_pkg::CNT_W'(i + 1);
      end
    end
  end

  // Single read port into the chain for read and the positional, last and first removals.
  always_comb begin
    rd_idx = in_data.position[bsl_pkg::IDX_W-1:0];
    if (in_data.action == bsl_pkg::ACT_REMOVE_LST) begin
      rd_idx = bsl_pkg::IDX_W'(count_r - 5'd1);
    end else if (in_data.action == bsl_pkg::ACT_REMOVE_FST) begin
      rd_idx = '0;
    end
  end
  assign rd_word = cell_word[rd_idx];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '0;

    cmd.op    = bsl_pkg::CELL_HOLD;
    cmd.idx   = '0;
    cmd.count = count_r;
    cmd.word  = (state_r == STATE_PURGE) ? key_r : in_data.value;

    unique case (state_r)
      STATE_IDLE: begin
        if (accept) begin
          out_strobe_nxt = 1'b1;
          if (in_data.wipe) begin
            count_nxt = '0;
          end else begin
            unique case (in_data.action) inside
              bsl_pkg::ACT_APPEND, bsl_pkg::ACT_PREPEND,
              bsl_pkg::ACT_INSERT_AT, bsl_pkg::ACT_SORTED_INS: begin
                if (full_now) begin
                  out_data_nxt.status = bsl_pkg::ST_FULL;
                end else if (in_data.action == bsl_pkg::ACT_INSERT_AT &&
                             in_data.position > count_r) begin
                  out_data_nxt.status = bsl_pkg::ST_BADPOS;
                end else begin
                  cmd.op    = bsl_pkg::CELL_INS;
                  count_nxt = count_r + 5'd1;
                  if (in_data.action == bsl_pkg::ACT_APPEND) begin
                    cmd.idx = count_r[bsl_pkg::IDX_W-1:0];
                  end else if (in_data.action == bsl_pkg::ACT_PREPEND) begin
                    cmd.idx = '0;
                  end else if (in_data.action == bsl_pkg::ACT_INSERT_AT) begin
                    cmd.idx = in_data.position[bsl_pkg::IDX_W-1:0];
                  end else begin
                    cmd.idx = sorted_pos[bsl_pkg::IDX_W-1:0];
                  end
                end
              end
              bsl_pkg::ACT_REMOVE_AT: begin
                if (in_data.position >= count_r) begin
                  out_data_nxt.status = bsl_pkg::ST_BADPOS;
                end else begin
                  cmd.op                = bsl_pkg::CELL_DEL;
                  cmd.idx               = rd_idx;
                  count_nxt             = count_r - 5'd1;
                  out_data_nxt.data_out = rd_word;
                end
              end
              bsl_pkg::ACT_REMOVE_LST, bsl_pkg::ACT_REMOVE_FST: begin
                if (count_r == '0) begin
                  out_data_nxt.status = bsl_pkg::ST_EMPTY;
                end else begin
                  cmd.op                = bsl_pkg::CELL_DEL;
                  cmd.idx               = rd_idx;
                  count_nxt             = count_r - 5'd1;
                  out_data_nxt.data_out = rd_word;
                end
              end
              bsl_pkg::ACT_REMOVE_VAL: begin
                // The result beat is issued once the purge finds no match.
                out_strobe_nxt = 1'b0;
                key_nxt        = in_data.value;
                state_nxt      = STATE_PURGE;
              end
              bsl_pkg::ACT_FIND: begin
                out_data_nxt.found_at = first_eq;
              end
              bsl_pkg::ACT_READ_AT: begin
                if (in_data.position >= count_r) begin
                  out_data_nxt.status = bsl_pkg::ST_BADPOS;
                end else begin
                  out_data_nxt.data_out = rd_word;
                end
              end
              bsl_pkg::ACT_WRITE_AT: begin
                if (in_data.position >= count_r) begin
                  out_data_nxt.status = bsl_pkg::ST_BADPOS;
                end else begin
                  cmd.op  = bsl_pkg::CELL_WRITE;
                  cmd.idx = in_data.position[bsl_pkg::IDX_W-1:0];
                end
              end
              default: begin
                out_data_nxt.status = bsl_pkg::ST_OK;
              end
            endcase
          end
        end
      end
      STATE_PURGE: begin
        if (any_eq) begin
          cmd.op    = bsl_pkg::CELL_DEL;
          cmd.idx   = first_eq[bsl_pkg::IDX_W-1:0];
          count_nxt = count_r - 5'd1;
        end else begin
          out_strobe_nxt = 1'b1;
          state_nxt      = STATE_IDLE;
        end
      end
      default: begin
        state_nxt = STATE_IDLE;
      end
    endcase

    out_data_nxt.entry_count = count_nxt;
    out_data_nxt.is_full     = count_nxt >= eff_limit;
    out_data_nxt.is_empty    = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= STATE_IDLE;
      count_r      <= '0;
      cap_r        <= bsl_pkg::CAPACITY_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
